### rtl/core/kft_pkg.sv
// Package for the key-file line tokenizer: state, result and phase types,
// byte and code constants, and the character-class and escape helpers.
// No dependencies.
package kft_pkg;

  // Parse phase, one-hot
  typedef enum logic [9:0] {
    PH_START      = 10'b00_0000_0001,
    PH_SECTION    = 10'b00_0000_0010,
    PH_BLANK      = 10'b00_0000_0100,
    PH_COMMENT    = 10'b00_0000_1000,
    PH_KEY        = 10'b00_0001_0000,
    PH_LOCALE     = 10'b00_0010_0000,
    PH_AFTER_KEY  = 10'b00_0100_0000,
    PH_VALUE_LEAD = 10'b00_1000_0000,
    PH_VALUE      = 10'b01_0000_0000,
    PH_HALT       = 10'b10_0000_0000
  } phase_t;

  // Result classes
  localparam logic [2:0] CLS_NONE    = 3'd0;
  localparam logic [2:0] CLS_SECTION = 3'd1;
  localparam logic [2:0] CLS_KEY     = 3'd2;
  localparam logic [2:0] CLS_LOCALE  = 3'd3;
  localparam logic [2:0] CLS_VALUE   = 3'd4;
  localparam logic [2:0] CLS_TEXT    = 3'd5;

  // Line kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_SECTION = 2'd1;
  localparam logic [1:0] KIND_KEYVAL  = 2'd2;
  localparam logic [1:0] KIND_TEXT    = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_BAD_HEADER = 3'd1;
  localparam logic [2:0] ERR_HDR_ESC    = 3'd2;
  localparam logic [2:0] ERR_EMPTY_KEY  = 3'd3;
  localparam logic [2:0] ERR_OPEN_LOC   = 3'd4;
  localparam logic [2:0] ERR_KEY_CHARS  = 3'd5;
  localparam logic [2:0] ERR_NO_EQUALS  = 3'd6;
  localparam logic [2:0] ERR_VALUE_ESC  = 3'd7;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_S   = 8'h73;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] held_data;
    logic       held_valid;
    logic       esc_pend;
    logic       esc_fault;
    logic       name_seen;
    logic       line_open;
    logic [2:0] sticky_err;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:      PH_START,
    held_data:  8'h00,
    held_valid: 1'b0,
    esc_pend:   1'b0,
    esc_fault:  1'b0,
    name_seen:  1'b0,
    line_open:  1'b0,
    sticky_err: ERR_OK
  };

  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] data;
    logic       done;
    logic [1:0] kind;
    logic [2:0] err;
  } result_t;

  typedef struct packed {
    logic [2:0] err;
    logic [1:0] kind;
  } close_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] data;
  } esc_t;

  function automatic logic is_key_char(input logic [7:0] b);
    return (b == CH_DASH) || (b >= CH_0 && b <= CH_9) ||
           (b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z);
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) ||
           (b == CH_FF) || (b == CH_CR);
  endfunction

  function automatic esc_t decode_escape(input logic [7:0] b);
    esc_t r;
    r.ok = 1'b1;
    case (b)
      CH_LC_S:   r.data = CH_SPACE;
      CH_LC_T:   r.data = CH_TAB;
      CH_LC_N:   r.data = CH_LF;
      CH_LC_R:   r.data = CH_CR;
      CH_BSLASH: r.data = CH_BSLASH;
      default: begin
        r.ok   = 1'b0;
        r.data = CH_NUL;
      end
    endcase
    return r;
  endfunction

  // How an open line ends: error code, or kind when the error is zero.
  function automatic close_t close_line(input state_t st);
    close_t c;
    c.err  = ERR_OK;
    c.kind = KIND_NONE;
    case (st.phase)
      PH_SECTION: begin
        if (!st.held_valid || st.held_data != CH_RBRACK || !st.name_seen)
          c.err = ERR_BAD_HEADER;
        else if (st.esc_pend || st.esc_fault)
          c.err = ERR_HDR_ESC;
        else
          c.kind = KIND_SECTION;
      end
      PH_BLANK, PH_COMMENT: c.kind = KIND_TEXT;
      PH_KEY, PH_AFTER_KEY: c.err = ERR_NO_EQUALS;
      PH_LOCALE:            c.err = ERR_OPEN_LOC;
      PH_VALUE_LEAD:        c.kind = KIND_KEYVAL;
      PH_VALUE: begin
        if (st.esc_pend) c.err = ERR_VALUE_ESC;
        else c.kind = KIND_KEYVAL;
      end
      default: c.kind = KIND_TEXT;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/kft_step.sv
// Next-state and result logic for one byte of the key-file tokenizer.
// Purely combinational; uses kft_pkg.
module kft_step #(
  parameter int LINE_NUMBER_BITS = 16
) (
  input  kft_pkg::state_t              st,
  input  logic [LINE_NUMBER_BITS-1:0]  cnt,
  input  logic [7:0]                   data,
  input  logic                         eod_flag,
  output kft_pkg::state_t              st_nxt,
  output logic [LINE_NUMBER_BITS-1:0]  cnt_nxt,
  output kft_pkg::result_t             res
);

  logic             eod;
  kft_pkg::close_t  cl;
  kft_pkg::esc_t    esc_held;
  kft_pkg::esc_t    esc_in;

  assign eod      = eod_flag || (data == kft_pkg::CH_NUL);
  assign cl       = kft_pkg::close_line(st);
  assign esc_held = kft_pkg::decode_escape(st.held_data);
  assign esc_in   = kft_pkg::decode_escape(data);

  always_comb begin
    st_nxt  = st;
    cnt_nxt = cnt;
    res     = '0;

    if (st.phase == kft_pkg::PH_HALT) begin
      res.err = st.sticky_err;
      if (eod) begin
        st_nxt  = kft_pkg::ST_RESET;
        cnt_nxt = LINE_NUMBER_BITS'(1);
      end
    end else if (eod || data == kft_pkg::CH_LF) begin
      if (st.line_open || data == kft_pkg::CH_LF) begin
        if (st.line_open && cl.err != kft_pkg::ERR_OK) begin
          res.err           = cl.err;
          st_nxt.sticky_err = cl.err;
          st_nxt.phase      = kft_pkg::PH_HALT;
        end else begin
          res.done = 1'b1;
          res.kind = st.line_open ? cl.kind : kft_pkg::KIND_TEXT;
          st_nxt   = kft_pkg::ST_RESET;
          st_nxt.sticky_err = st.sticky_err;
          if (cnt != {LINE_NUMBER_BITS{1'b1}})
            cnt_nxt = cnt + LINE_NUMBER_BITS'(1);
        end
      end
      if (eod) begin
        st_nxt  = kft_pkg::ST_RESET;
        cnt_nxt = LINE_NUMBER_BITS'(1);
      end
    end else begin
      case (st.phase)
        kft_pkg::PH_START: begin
          st_nxt.line_open = 1'b1;
          if (data == kft_pkg::CH_LBRACK) begin
            st_nxt.phase = kft_pkg::PH_SECTION;
          end else if (kft_pkg::is_ws(data)) begin
            st_nxt.phase = kft_pkg::PH_BLANK;
            res.cls      = kft_pkg::CLS_TEXT;
            res.data     = data;
          end else if (data == kft_pkg::CH_HASH) begin
            st_nxt.phase = kft_pkg::PH_COMMENT;
            res.cls      = kft_pkg::CLS_TEXT;
            res.data     = data;
          end else if (kft_pkg::is_key_char(data)) begin
            st_nxt.phase = kft_pkg::PH_KEY;
            res.cls      = kft_pkg::CLS_KEY;
            res.data     = data;
          end else begin
            res.err           = kft_pkg::ERR_EMPTY_KEY;
            st_nxt.sticky_err = kft_pkg::ERR_EMPTY_KEY;
            st_nxt.phase      = kft_pkg::PH_HALT;
          end
        end
        kft_pkg::PH_SECTION: begin
          // the byte held from last time goes through the unescaper now
          if (st.held_valid) begin
            st_nxt.name_seen = 1'b1;
            if (!st.esc_fault) begin
              if (st.esc_pend) begin
                st_nxt.esc_pend = 1'b0;
                if (esc_held.ok) begin
                  res.cls  = kft_pkg::CLS_SECTION;
                  res.data = esc_held.data;
                end else begin
                  st_nxt.esc_fault = 1'b1;
                end
              end else if (st.held_data == kft_pkg::CH_BSLASH) begin
                st_nxt.esc_pend = 1'b1;
              end else begin
                res.cls  = kft_pkg::CLS_SECTION;
                res.data = st.held_data;
              end
            end
          end
          st_nxt.held_data  = data;
          st_nxt.held_valid = 1'b1;
        end
        kft_pkg::PH_BLANK: begin
          if (kft_pkg::is_ws(data)) begin
            res.cls  = kft_pkg::CLS_TEXT;
            res.data = data;
          end else begin
            res.err           = kft_pkg::ERR_EMPTY_KEY;
            st_nxt.sticky_err = kft_pkg::ERR_EMPTY_KEY;
            st_nxt.phase      = kft_pkg::PH_HALT;
          end
        end
        kft_pkg::PH_COMMENT: begin
          res.cls  = kft_pkg::CLS_TEXT;
          res.data = data;
        end
        kft_pkg::PH_KEY: begin
          if (kft_pkg::is_key_char(data)) begin
            res.cls  = kft_pkg::CLS_KEY;
            res.data = data;
          end else if (data == kft_pkg::CH_LBRACK) begin
            st_nxt.phase = kft_pkg::PH_LOCALE;
          end else if (data == kft_pkg::CH_SPACE) begin
            st_nxt.phase = kft_pkg::PH_AFTER_KEY;
          end else if (data == kft_pkg::CH_EQUALS) begin
            st_nxt.phase = kft_pkg::PH_VALUE_LEAD;
          end else begin
            res.err           = kft_pkg::ERR_KEY_CHARS;
            st_nxt.sticky_err = kft_pkg::ERR_KEY_CHARS;
            st_nxt.phase      = kft_pkg::PH_HALT;
          end
        end
        kft_pkg::PH_LOCALE: begin
          if (data == kft_pkg::CH_RBRACK) begin
            st_nxt.phase = kft_pkg::PH_AFTER_KEY;
          end else begin
            res.cls  = kft_pkg::CLS_LOCALE;
            res.data = data;
          end
        end
        kft_pkg::PH_AFTER_KEY: begin
          if (data == kft_pkg::CH_EQUALS) begin
            st_nxt.phase = kft_pkg::PH_VALUE_LEAD;
          end else if (data != kft_pkg::CH_SPACE) begin
            res.err           = kft_pkg::ERR_KEY_CHARS;
            st_nxt.sticky_err = kft_pkg::ERR_KEY_CHARS;
            st_nxt.phase      = kft_pkg::PH_HALT;
          end
        end
        kft_pkg::PH_VALUE_LEAD, kft_pkg::PH_VALUE: begin
          // leading spaces after '=' are skipped
          if (!(st.phase == kft_pkg::PH_VALUE_LEAD && data == kft_pkg::CH_SPACE)) begin
            st_nxt.phase = kft_pkg::PH_VALUE;
            if (st.esc_pend) begin
              st_nxt.esc_pend = 1'b0;
              if (esc_in.ok) begin
                res.cls  = kft_pkg::CLS_VALUE;
                res.data = esc_in.data;
              end else begin
                res.err           = kft_pkg::ERR_VALUE_ESC;
                st_nxt.sticky_err = kft_pkg::ERR_VALUE_ESC;
                st_nxt.phase      = kft_pkg::PH_HALT;
              end
            end else if (data == kft_pkg::CH_BSLASH) begin
              st_nxt.esc_pend = 1'b1;
            end else begin
              res.cls  = kft_pkg::CLS_VALUE;
              res.data = data;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/keyfile_line_tokenizer.sv
// Top level of the key-file line tokenizer: input register, parser state,
// result register. Depends on kft_pkg and kft_step.
//
// Usage:
//   Input channel (in_valid/in_ready): one text byte per word, plus an
//   end-of-data flag. A zero byte also counts as end of data. End of data
//   closes any open line and puts the parser back to its start state.
//   Output channel (out_valid/out_ready): exactly one result word per input
//   word: byte class, decoded byte, line-done flag with line kind, fault
//   code and line number. Section names come out one byte late, so the
//   closing ']' never appears.
//   Path: the accepting edge loads the input register; the word then moves
//   on into the result register when that register is empty or being read.
//   Throughput: one word per cycle, sustained while out_ready stays high;
//   the parser state loop is one pass through kft_step into st_r.
//   Stall: when out_ready is low the result register holds; the input
//   register still takes one more word, then in_ready drops until the
//   result is taken.
//   Reset (rst_n low, synchronous): both registers empty, parser at line
//   start, line number 1, no error.
module keyfile_line_tokenizer #(
  parameter int LINE_NUMBER_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_end_of_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_class,
  output logic [7:0]                   out_byte,
  output logic                         out_line_done,
  output logic [1:0]                   out_line_kind,
  output logic [2:0]                   out_fault_code,
  output logic [LINE_NUMBER_BITS-1:0]  out_line_number
);

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_data_r;
  logic        s1_eod_r;

  // parser state
  kft_pkg::state_t              st_r;
  kft_pkg::state_t              st_nxt;
  logic [LINE_NUMBER_BITS-1:0]  cnt_r;
  logic [LINE_NUMBER_BITS-1:0]  cnt_nxt;
  kft_pkg::result_t             res;

  // result register
  logic                         out_valid_r;
  kft_pkg::result_t             out_res_r;
  logic [LINE_NUMBER_BITS-1:0]  out_num_r;

  logic s1_move;   // word in input register goes to result register

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;

  kft_step #(
    .LINE_NUMBER_BITS (LINE_NUMBER_BITS)
  ) u_step (
    .st       (st_r),
    .cnt      (cnt_r),
    .data     (s1_data_r),
    .eod_flag (s1_eod_r),
    .st_nxt   (st_nxt),
    .cnt_nxt  (cnt_nxt),
    .res      (res)
  );

  // control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= kft_pkg::ST_RESET;
      cnt_r       <= LINE_NUMBER_BITS'(1);
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_move) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
        cnt_r       <= cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data_byte;
      s1_eod_r  <= in_end_of_data;
    end
    if (s1_move) begin
      out_res_r <= res;
      out_num_r <= cnt_r;   // number of the line this byte belongs to
    end
  end

  assign out_valid       = out_valid_r;
  assign out_class       = out_res_r.cls;
  assign out_byte        = out_res_r.data;
  assign out_line_done   = out_res_r.done;
  assign out_line_kind   = out_res_r.kind;
  assign out_fault_code  = out_res_r.err;
  assign out_line_number = out_num_r;

endmodule
